/* hw/rtl/stt_pkg.sv */
`default_nettype none

package stt_pkg;

  // table geometry
  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned OUT_IDX_W  = 4;

  // field widths
  localparam int unsigned TOKEN_W = 64;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CREATE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVALIDATE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OLD  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE      = 1'b1;

  // configuration reset values
  localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 24'd3600;
  localparam logic [CFG_W-1:0] MAX_AGE_RST      = 24'd86400;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture a new transaction and restart the scan
    logic scan_en;  // advance the slot walk
    logic commit;   // write the table and load the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } ctrl_status_t;

endpackage : stt_pkg

`default_nettype wire

/* hw/rtl/stt_ctrl.sv */
`default_nettype none

module stt_ctrl
  import stt_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output ctrl_cmd_t         cmd_o,
  input  wire ctrl_status_t status_i
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the result register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule : stt_ctrl

`default_nettype wire

/* hw/rtl/stt_dp.sv */
`default_nettype none

module stt_dp
  import stt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ctrl_cmd_t            cmd_i,
  output ctrl_status_t              status_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic [CMD_W-1:0]     command_i,
  input  wire logic [TOKEN_W-1:0]   token_upper_i,
  input  wire logic [TOKEN_W-1:0]   token_lower_i,
  input  wire logic [TIME_W-1:0]    current_time_i,
  output logic                      accepted_o,
  output logic [STAT_W-1:0]         status_code_o,
  output logic [OUT_IDX_W-1:0]      slot_index_o
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  // configuration
  logic [CFG_W-1:0] idle_timeout_q, max_age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q <= IDLE_TIMEOUT_RST;
      max_age_q      <= MAX_AGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data_i;
        CFG_MAX_AGE:      max_age_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured transaction
  logic [CMD_W-1:0]   cmd_q;
  logic [TOKEN_W-1:0] tok_hi_q, tok_lo_q;
  logic [TIME_W-1:0]  now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q    <= command_i;
      tok_hi_q <= token_upper_i;
      tok_lo_q <= token_lower_i;
      now_q    <= current_time_i;
    end
  end

  // slot storage
  logic [TOKEN_W-1:0]    tok_hi_mem [SLOT_COUNT];
  logic [TOKEN_W-1:0]    tok_lo_mem [SLOT_COUNT];
  logic [TIME_W-1:0]     exp_mem    [SLOT_COUNT];
  logic [TIME_W-1:0]     iss_mem    [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q;

  // read side of the walk
  logic [SLOT_W-1:0]  rd_addr_q, eval_idx_q;
  logic               issue_vld_q, eval_vld_q;
  logic [TOKEN_W-1:0] rd_tok_hi_q, rd_tok_lo_q;
  logic [TIME_W-1:0]  rd_exp_q, rd_iss_q;
  logic               rd_valid_q;

  always_ff @(posedge clk_i) begin
    rd_tok_hi_q <= tok_hi_mem[rd_addr_q];
    rd_tok_lo_q <= tok_lo_mem[rd_addr_q];
    rd_exp_q    <= exp_mem[rd_addr_q];
    rd_iss_q    <= iss_mem[rd_addr_q];
    rd_valid_q  <= valid_q[rd_addr_q];
    eval_idx_q  <= rd_addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q   <= '0;
      issue_vld_q <= 1'b0;
      eval_vld_q  <= 1'b0;
    end else if (cmd_i.load) begin
      rd_addr_q   <= '0;
      issue_vld_q <= 1'b1;
      eval_vld_q  <= 1'b0;
    end else if (cmd_i.scan_en) begin
      rd_addr_q   <= rd_addr_q + SLOT_W'(1);
      eval_vld_q  <= issue_vld_q;
      if (rd_addr_q == LAST_SLOT) begin
        issue_vld_q <= 1'b0;
      end
    end
  end

  // per slot evaluation
  logic slot_free, slot_live, slot_match, hit_now, take_oldest;

  logic              hit_q;
  logic [SLOT_W-1:0] sel_q, old_idx_q;
  logic [TIME_W-1:0] hit_iss_q, old_exp_q;

  always_comb begin
    slot_match  = rd_valid_q && (rd_tok_hi_q == tok_hi_q) && (rd_tok_lo_q == tok_lo_q);
    slot_free   = !rd_valid_q || (rd_exp_q <= now_q);
    slot_live   = rd_valid_q && (rd_exp_q > now_q);
    hit_now     = 1'b0;
    take_oldest = 1'b0;
    if (eval_vld_q && !hit_q) begin
      case (cmd_q)
        CMD_CREATE: begin
          hit_now     = slot_free;
          take_oldest = !slot_free && ((eval_idx_q == '0) || (rd_exp_q < old_exp_q));
        end
        CMD_CHECK:      hit_now = slot_live && slot_match;
        CMD_INVALIDATE: hit_now = slot_match;
        default:        hit_now = 1'b0;
      endcase
    end
  end

  assign status_o.scan_done = eval_vld_q && (hit_now || hit_q || (eval_idx_q == LAST_SLOT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q <= 1'b0;
    end else if (cmd_i.scan_en && hit_now) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en && hit_now) begin
      sel_q     <= eval_idx_q;
      hit_iss_q <= rd_iss_q;
    end
    if (cmd_i.scan_en && take_oldest) begin
      old_idx_q <= eval_idx_q;
      old_exp_q <= rd_exp_q;
    end
  end

  // commit step
  logic [TIME_W:0]    exp_sum;
  logic [TIME_W-1:0]  exp_new;
  logic               too_old;
  logic [SLOT_W-1:0]  wr_idx;
  logic               wr_all, wr_exp, wr_clear;
  logic               res_acc;
  logic [STAT_W-1:0]  res_stat;
  logic [SLOT_W-1:0]  res_idx;

  always_comb begin
    exp_sum  = {1'b0, now_q} + {{(TIME_W + 1 - CFG_W){1'b0}}, idle_timeout_q};
    exp_new  = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
    // a current time behind the issue time counts as age zero
    too_old  = (now_q >= hit_iss_q) &&
               ((now_q - hit_iss_q) > {{(TIME_W - CFG_W){1'b0}}, max_age_q});
    wr_idx   = sel_q;
    wr_all   = 1'b0;
    wr_exp   = 1'b0;
    wr_clear = 1'b0;
    res_acc  = 1'b0;
    res_stat = STAT_NONE;
    res_idx  = '0;
    case (cmd_q)
      CMD_CREATE: begin
        wr_idx   = hit_q ? sel_q : old_idx_q;
        wr_all   = 1'b1;
        res_acc  = 1'b1;
        res_stat = STAT_OK;
        res_idx  = wr_idx;
      end
      CMD_CHECK: begin
        if (hit_q && too_old) begin
          res_stat = STAT_OLD;
        end else if (hit_q) begin
          wr_exp   = 1'b1;
          res_acc  = 1'b1;
          res_stat = STAT_OK;
          res_idx  = sel_q;
        end
      end
      CMD_INVALIDATE: begin
        if (hit_q) begin
          wr_clear = 1'b1;
          res_acc  = 1'b1;
          res_stat = STAT_OK;
          res_idx  = sel_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (wr_all) begin
        tok_hi_mem[wr_idx] <= tok_hi_q;
        tok_lo_mem[wr_idx] <= tok_lo_q;
        iss_mem[wr_idx]    <= now_q;
      end
      if (wr_all || wr_exp) begin
        exp_mem[wr_idx] <= exp_new;
      end
    end
  end

  // a cleared slot only needs its valid bit dropped, stale fields are never looked at
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      if (wr_all) begin
        valid_q[wr_idx] <= 1'b1;
      end else if (wr_clear) begin
        valid_q[wr_idx] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      accepted_o    <= res_acc;
      status_code_o <= res_stat;
      slot_index_o  <= OUT_IDX_W'(res_idx);
    end
  end

endmodule : stt_dp

`default_nettype wire

/* hw/rtl/session_table_with_expiry.sv */
// session table with expiry: sixteen slots of token, expiry, issue time and valid
// input channel (in_valid_i / in_ready_o) carries one command transaction:
//   command_i, token_upper_i, token_lower_i, current_time_i
// output channel (out_valid_o / out_ready_i) returns one result transaction:
//   accepted_o, status_o, slot_index_o
// config port: cfg_we_i writes cfg_data_i into register cfg_idx_i at once (0 idle
//   timeout, 1 max session age); the user writes only while the block is idle,
// which the block itself does not enforce
// the slot walk reads one slot per cycle from the slot memories into the read
// registers, evaluates it there and stops at the first hit or the last slot
// one transaction is in flight at a time; input ready returns once the finish
// state has loaded the result, so the next transaction waits for that commit
// results sit in an output register, so a new transaction is taken while the
// previous result still waits; a stalled receiver only holds the next result
// at its final step until the register drains
// reset empties every slot (valid bits cleared) and restores the timeout
// registers to 3600 and 86400 seconds
`default_nettype none

module session_table_with_expiry
  import stt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // command transaction
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [CMD_W-1:0]     command_i,
  input  wire logic [TOKEN_W-1:0]   token_upper_i,
  input  wire logic [TOKEN_W-1:0]   token_lower_i,
  input  wire logic [TIME_W-1:0]    current_time_i,
  // result transaction
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      accepted_o,
  output logic [STAT_W-1:0]         status_o,
  output logic [OUT_IDX_W-1:0]      slot_index_o,
  // configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // sequencer: idle, slot walk, commit into the result register
  stt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // slot memories, search, expiry arithmetic and result register
  stt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .command_i      (command_i),
    .token_upper_i  (token_upper_i),
    .token_lower_i  (token_lower_i),
    .current_time_i (current_time_i),
    .accepted_o     (accepted_o),
    .status_code_o  (status_o),
    .slot_index_o   (slot_index_o)
  );

endmodule : session_table_with_expiry

`default_nettype wire
